/* sv/triangle_face_normal_assert.svh */
// Assertion macros used by the triangle face normal top level.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TFN_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TFN_ASSERT(lbl, ante, cons, msg)
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/tfn_pkg.sv */
// Shared constants, types and helpers of the triangle face normal block.
package tfn_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int COLOR_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int NORM_W = 16;
	localparam int MAG_W = 31;
	localparam int SUMSQ_W = 64;
	localparam int ROOT_W = 32;
	localparam int SQRT_STEPS = 4;
	localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
	localparam int SMALL_W = 19;
	localparam int SMALL_SQ_W = 40;
	localparam logic [SMALL_SQ_W-1:0] LEN_LIMIT_SQ = 40'd184467440737;
	localparam int Q_FRAC = 15;
	localparam int Q_W = 20;
	localparam int DIV_STEPS = 4;
	localparam int DIV_STAGES = Q_W / DIV_STEPS;
	localparam int NUM_W = MAG_W + Q_FRAC + 1;
	localparam logic [Q_W-1:0] Q_POS_MAX = 20'd32767;
	localparam logic [Q_W-1:0] Q_NEG_MAX = 20'd32768;
	localparam logic [NORM_W-1:0] NORM_ONE = 16'd32767;

	typedef enum logic [CFG_IDX_W-1:0] {REG_RED, REG_GREEN, REG_BLUE, REG_ALPHA} reg_idx_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] alpha;
	} color_t;

	// Position of the highest set bit in a byte, zero for an empty byte.
	function automatic logic [2:0] msb8(input logic [7:0] v);
		logic [2:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) begin
				p = 3'(i);
			end
		end
		return p;
	endfunction
endpackage

/* sv/tfn_cross.sv */
// Edge vectors and exact cross product magnitudes, four pipeline stages.
module tfn_cross #(
	parameter int W = tfn_pkg::COORD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [9*W-1:0]     pos_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [9*W-1:0]     pos_out,
	output logic [3*(2*W+3)-1:0] mag_out,
	output logic [2:0]         neg_out
);
	localparam int EW = W + 1;
	localparam int PW = 2 * EW;
	localparam int MW = PW + 1;
	localparam int NST = 4;

	logic [NST-1:0] v_s, en, vin;
	logic signed [EW-1:0] edg_d [6];
	logic signed [EW-1:0] edg_s1 [6];
	logic signed [PW-1:0] prod_s2 [6];
	logic signed [MW-1:0] diff_s3 [3];
	logic [MW-1:0] mag_s4 [3];
	logic [2:0] neg_s4;
	logic [9*W-1:0] pos_s1, pos_s2, pos_s3, pos_s4;

	always_comb begin
		en[NST-1] = !v_s[NST-1] || out_ready;
		for (int g = NST - 2; g >= 0; g--) begin
			en[g] = !v_s[g] || en[g+1];
		end
	end
	assign vin = {v_s[NST-2:0], in_valid};

	// e1 = b - a, e2 = c - a
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			edg_d[i] = $signed({pos_in[(3+i)*W+W-1], pos_in[(3+i)*W +: W]})
				- $signed({pos_in[i*W+W-1], pos_in[i*W +: W]});
			edg_d[3+i] = $signed({pos_in[(6+i)*W+W-1], pos_in[(6+i)*W +: W]})
				- $signed({pos_in[i*W+W-1], pos_in[i*W +: W]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int g = 0; g < NST; g++) begin
				if (en[g]) begin
					v_s[g] <= vin[g];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			edg_s1 <= edg_d;
			pos_s1 <= pos_in;
		end
		if (en[1]) begin
			prod_s2[0] <= edg_s1[1] * edg_s1[5];
			prod_s2[1] <= edg_s1[2] * edg_s1[4];
			prod_s2[2] <= edg_s1[2] * edg_s1[3];
			prod_s2[3] <= edg_s1[0] * edg_s1[5];
			prod_s2[4] <= edg_s1[0] * edg_s1[4];
			prod_s2[5] <= edg_s1[1] * edg_s1[3];
			pos_s2 <= pos_s1;
		end
		if (en[2]) begin
			for (int k = 0; k < 3; k++) begin
				diff_s3[k] <= MW'(prod_s2[2*k]) - MW'(prod_s2[2*k+1]);
			end
			pos_s3 <= pos_s2;
		end
		if (en[3]) begin
			for (int k = 0; k < 3; k++) begin
				mag_s4[k] <= diff_s3[k][MW-1] ? $unsigned(-diff_s3[k]) : $unsigned(diff_s3[k]);
				neg_s4[k] <= diff_s3[k][MW-1];
			end
			pos_s4 <= pos_s3;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag_out[k*MW +: MW] = mag_s4[k];
		end
	end
	assign neg_out = neg_s4;
	assign pos_out = pos_s4;
	assign in_ready = en[0];
	assign out_valid = v_s[NST-1];
endmodule

/* sv/tfn_scale.sv */
// Length threshold, common right shift and sum of squares, five pipeline stages.
module tfn_scale #(
	parameter int W = tfn_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [9*W-1:0]                      pos_in,
	input  logic [3*(2*W+3)-1:0]                mag_in,
	input  logic [2:0]                          neg_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [9*W-1:0]                      pos_out,
	output logic [3*tfn_pkg::MAG_W-1:0]         m_out,
	output logic [2:0]                          neg_out,
	output logic                                nz_out,
	output logic [tfn_pkg::SUMSQ_W-1:0]         sum_out
);
	localparam int MW = 2 * W + 3;
	localparam int NCH = (MW + 7) / 8;
	localparam int PADW = NCH * 8;
	localparam int SHW = $clog2(PADW);
	localparam int SSQ_W = 2 * tfn_pkg::SMALL_W;
	localparam int SQW = 2 * tfn_pkg::MAG_W;
	localparam int NST = 5;

	logic [NST-1:0] v_s, en, vin;
	logic [MW-1:0] mag_d [3];
	logic [MW-1:0] orv_d;
	logic [PADW-1:0] orv_pad;
	logic [SHW-1:0] msb_d, sh_d;
	logic nz_d;

	logic [MW-1:0] mag_s1 [3];
	logic [NCH-1:0] cnz_s1;
	logic [2:0] cpos_s1 [NCH];
	logic small_s1;
	logic [SSQ_W-1:0] ssq_s1 [3];
	logic [MW-1:0] mag_s2 [3];
	logic [SHW-1:0] sh_s2;
	logic [tfn_pkg::MAG_W-1:0] m_s3 [3], m_s4 [3], m_s5 [3];
	logic [SQW-1:0] sq_s4 [3];
	logic [tfn_pkg::SUMSQ_W-1:0] sum_s5;
	logic nz_s2, nz_s3, nz_s4, nz_s5;
	logic [2:0] neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [9*W-1:0] pos_s1, pos_s2, pos_s3, pos_s4, pos_s5;

	always_comb begin
		en[NST-1] = !v_s[NST-1] || out_ready;
		for (int g = NST - 2; g >= 0; g--) begin
			en[g] = !v_s[g] || en[g+1];
		end
	end
	assign vin = {v_s[NST-2:0], in_valid};

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag_d[k] = mag_in[k*MW +: MW];
		end
		orv_d = mag_d[0] | mag_d[1] | mag_d[2];
	end
	assign orv_pad = PADW'(orv_d);

	// Highest set bit over all three magnitudes, byte by byte.
	always_comb begin
		msb_d = '0;
		for (int c = 0; c < NCH; c++) begin
			if (cnz_s1[c]) begin
				msb_d = SHW'(c * 8) | SHW'(cpos_s1[c]);
			end
		end
		sh_d = (msb_d >= SHW'(tfn_pkg::MAG_W)) ? msb_d - SHW'(tfn_pkg::MAG_W - 1) : '0;
	end

	// Large magnitudes always pass; small ones take the exact squared length.
	assign nz_d = !small_s1 || ((tfn_pkg::SMALL_SQ_W'(ssq_s1[0]) + tfn_pkg::SMALL_SQ_W'(ssq_s1[1])
		+ tfn_pkg::SMALL_SQ_W'(ssq_s1[2])) > tfn_pkg::LEN_LIMIT_SQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int g = 0; g < NST; g++) begin
				if (en[g]) begin
					v_s[g] <= vin[g];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int c = 0; c < NCH; c++) begin
				cnz_s1[c] <= |orv_pad[c*8 +: 8];
				cpos_s1[c] <= tfn_pkg::msb8(orv_pad[c*8 +: 8]);
			end
			for (int k = 0; k < 3; k++) begin
				ssq_s1[k] <= SSQ_W'(mag_d[k][tfn_pkg::SMALL_W-1:0])
					* SSQ_W'(mag_d[k][tfn_pkg::SMALL_W-1:0]);
			end
			small_s1 <= (orv_d >> tfn_pkg::SMALL_W) == '0;
			mag_s1 <= mag_d;
			neg_s1 <= neg_in;
			pos_s1 <= pos_in;
		end
		if (en[1]) begin
			sh_s2 <= sh_d;
			nz_s2 <= nz_d;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			pos_s2 <= pos_s1;
		end
		if (en[2]) begin
			for (int k = 0; k < 3; k++) begin
				m_s3[k] <= tfn_pkg::MAG_W'(mag_s2[k] >> sh_s2);
			end
			nz_s3 <= nz_s2;
			neg_s3 <= neg_s2;
			pos_s3 <= pos_s2;
		end
		if (en[3]) begin
			for (int k = 0; k < 3; k++) begin
				sq_s4[k] <= SQW'(m_s3[k]) * SQW'(m_s3[k]);
			end
			m_s4 <= m_s3;
			nz_s4 <= nz_s3;
			neg_s4 <= neg_s3;
			pos_s4 <= pos_s3;
		end
		if (en[4]) begin
			sum_s5 <= tfn_pkg::SUMSQ_W'(sq_s4[0]) + tfn_pkg::SUMSQ_W'(sq_s4[1])
				+ tfn_pkg::SUMSQ_W'(sq_s4[2]);
			m_s5 <= m_s4;
			nz_s5 <= nz_s4;
			neg_s5 <= neg_s4;
			pos_s5 <= pos_s4;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m_out[k*tfn_pkg::MAG_W +: tfn_pkg::MAG_W] = m_s5[k];
		end
	end
	assign sum_out = sum_s5;
	assign nz_out = nz_s5;
	assign neg_out = neg_s5;
	assign pos_out = pos_s5;
	assign in_ready = en[0];
	assign out_valid = v_s[NST-1];
endmodule

/* sv/tfn_sqrt.sv */
// Pipelined integer square root, four result bits per stage.
module tfn_sqrt #(
	parameter int W = tfn_pkg::COORD_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [9*W-1:0]                   pos_in,
	input  logic [3*tfn_pkg::MAG_W-1:0]      m_in,
	input  logic [2:0]                       neg_in,
	input  logic                             nz_in,
	input  logic [tfn_pkg::SUMSQ_W-1:0]      sum_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [9*W-1:0]                   pos_out,
	output logic [3*tfn_pkg::MAG_W-1:0]      m_out,
	output logic [2:0]                       neg_out,
	output logic                             nz_out,
	output logic [tfn_pkg::ROOT_W-1:0]       root_out
);
	localparam int NST = tfn_pkg::SQRT_STAGES;
	localparam int SW = 9 * W + 3 * tfn_pkg::MAG_W + 4;
	localparam int RW = tfn_pkg::ROOT_W;
	localparam int REM_W = RW + 2;
	localparam int SQ_W = tfn_pkg::SUMSQ_W;

	logic [NST-1:0] v_s, en, vin;
	logic [SW-1:0] side_s [NST];
	logic [SQ_W-1:0] rad_s [NST];
	logic [REM_W-1:0] rem_s [NST];
	logic [RW-1:0] root_s [NST];

	always_comb begin
		en[NST-1] = !v_s[NST-1] || out_ready;
		for (int g = NST - 2; g >= 0; g--) begin
			en[g] = !v_s[g] || en[g+1];
		end
	end
	assign vin = {v_s[NST-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int g = 0; g < NST; g++) begin
				if (en[g]) begin
					v_s[g] <= vin[g];
				end
			end
		end
	end

	for (genvar g = 0; g < NST; g++) begin : g_stage
		logic [SW-1:0] side_p;
		logic [SQ_W-1:0] rad_p, rad_n;
		logic [REM_W-1:0] rem_p, rem_n, trial;
		logic [RW-1:0] root_p, root_n;

		if (g == 0) begin : g_head
			assign side_p = {pos_in, m_in, neg_in, nz_in};
			assign rad_p = sum_in;
			assign rem_p = '0;
			assign root_p = '0;
		end else begin : g_body
			assign side_p = side_s[g-1];
			assign rad_p = rad_s[g-1];
			assign rem_p = rem_s[g-1];
			assign root_p = root_s[g-1];
		end

		// Bring down two radicand bits, try root*4+1, keep it if it fits.
		always_comb begin
			rad_n = rad_p;
			rem_n = rem_p;
			root_n = root_p;
			trial = '0;
			for (int i = 0; i < tfn_pkg::SQRT_STEPS; i++) begin
				rem_n = {rem_n[REM_W-3:0], rad_n[SQ_W-1 -: 2]};
				rad_n = rad_n << 2;
				trial = {root_n, 2'b01};
				if (rem_n >= trial) begin
					rem_n = rem_n - trial;
					root_n = {root_n[RW-2:0], 1'b1};
				end else begin
					root_n = {root_n[RW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				side_s[g] <= side_p;
				rad_s[g] <= rad_n;
				rem_s[g] <= rem_n;
				root_s[g] <= root_n;
			end
		end
	end

	assign {pos_out, m_out, neg_out, nz_out} = side_s[NST-1];
	assign root_out = root_s[NST-1];
	assign in_ready = en[0];
	assign out_valid = v_s[NST-1];
endmodule

/* sv/tfn_div.sv */
// Rounded quotients m*2^15/r for the three components, then sign and saturation.
module tfn_div #(
	parameter int W = tfn_pkg::COORD_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [9*W-1:0]                   pos_in,
	input  logic [3*tfn_pkg::MAG_W-1:0]      m_in,
	input  logic [2:0]                       neg_in,
	input  logic                             nz_in,
	input  logic [tfn_pkg::ROOT_W-1:0]       root_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [9*W-1:0]                   pos_out,
	output logic [3*tfn_pkg::NORM_W-1:0]     norm_out
);
	localparam int ND = tfn_pkg::DIV_STAGES;
	localparam int NST = ND + 2;
	localparam int SW = 9 * W + 4;
	localparam int NW = tfn_pkg::NUM_W;
	localparam int QW = tfn_pkg::Q_W;
	localparam int RW = tfn_pkg::ROOT_W;
	localparam int DW = RW + QW;
	localparam int MGW = tfn_pkg::MAG_W;
	localparam int NMW = tfn_pkg::NORM_W;

	logic [NST-1:0] v_s, en, vin;
	logic [SW-1:0] side_s1;
	logic [NW-1:0] num_s1 [3];
	logic [RW-1:0] root_s1;
	logic [SW-1:0] side_d [ND];
	logic [NW-1:0] rem_d [ND][3];
	logic [QW-1:0] q_d [ND][3];
	logic [RW-1:0] root_d [ND];
	logic [9*W-1:0] pos_o;
	logic [NMW-1:0] norm_o [3];
	logic [QW-1:0] qc_o [3];
	logic [9*W-1:0] pos_l;
	logic [2:0] neg_l;
	logic nz_l;

	always_comb begin
		en[NST-1] = !v_s[NST-1] || out_ready;
		for (int g = NST - 2; g >= 0; g--) begin
			en[g] = !v_s[g] || en[g+1];
		end
	end
	assign vin = {v_s[NST-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int g = 0; g < NST; g++) begin
				if (en[g]) begin
					v_s[g] <= vin[g];
				end
			end
		end
	end

	// Numerator with half the divisor added for round to nearest.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < 3; k++) begin
				num_s1[k] <= NW'({m_in[k*MGW +: MGW], {tfn_pkg::Q_FRAC{1'b0}}})
					+ NW'(root_in >> 1);
			end
			root_s1 <= root_in;
			side_s1 <= {pos_in, neg_in, nz_in};
		end
	end

	for (genvar g = 0; g < ND; g++) begin : g_stage
		logic [SW-1:0] side_p;
		logic [NW-1:0] rem_p [3];
		logic [QW-1:0] q_p [3];
		logic [RW-1:0] root_p;
		logic [NW-1:0] rem_n [3];
		logic [QW-1:0] q_n [3];
		logic [DW-1:0] dv;
		int kb;

		if (g == 0) begin : g_head
			assign side_p = side_s1;
			assign rem_p = num_s1;
			assign q_p = '{default: '0};
			assign root_p = root_s1;
		end else begin : g_body
			assign side_p = side_d[g-1];
			assign rem_p = rem_d[g-1];
			assign q_p = q_d[g-1];
			assign root_p = root_d[g-1];
		end

		// Restoring division, quotient bits from the top down.
		always_comb begin
			rem_n = rem_p;
			q_n = q_p;
			dv = '0;
			kb = 0;
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < tfn_pkg::DIV_STEPS; i++) begin
					kb = QW - 1 - (g * tfn_pkg::DIV_STEPS + i);
					dv = DW'(root_p) << kb;
					if (DW'(rem_n[k]) >= dv) begin
						rem_n[k] = rem_n[k] - NW'(dv);
						q_n[k] = q_n[k] | (QW'(1) << kb);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[g+1]) begin
				side_d[g] <= side_p;
				rem_d[g] <= rem_n;
				q_d[g] <= q_n;
				root_d[g] <= root_p;
			end
		end
	end

	assign {pos_l, neg_l, nz_l} = side_d[ND-1];

	// Apply sign and saturate; fall back to +Y for a degenerate triangle.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qc_o[k] = (q_d[ND-1][k] > tfn_pkg::Q_NEG_MAX) ? tfn_pkg::Q_NEG_MAX : q_d[ND-1][k];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			pos_o <= pos_l;
			for (int k = 0; k < 3; k++) begin
				if (!nz_l) begin
					norm_o[k] <= (k == 1) ? tfn_pkg::NORM_ONE : '0;
				end else if (!neg_l[k]) begin
					norm_o[k] <= (q_d[ND-1][k] > tfn_pkg::Q_POS_MAX) ? tfn_pkg::NORM_ONE
						: NMW'(q_d[ND-1][k]);
				end else begin
					norm_o[k] <= NMW'(QW'(0) - qc_o[k]);
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			norm_out[k*NMW +: NMW] = norm_o[k];
		end
	end
	assign pos_out = pos_o;
	assign in_ready = en[0];
	assign out_valid = v_s[NST-1];
endmodule

/* sv/triangle_face_normal.sv */
// Top level of the triangle face normal block: pipeline, vertex output and color registers.
//
// Input channel (in_valid/in_ready): one item is a triangle, three vertices a, b, c
// in signed Q16.16. Output channel (out_valid/out_ready): three items per triangle,
// vertex a, b, c in that order, each with its position, the shared unit normal in
// Q1.15 and the current color; last_vertex marks vertex c.
// Config channel (cfg_valid/cfg_ready): cfg_index 0..3 selects red, green, blue,
// alpha; cfg_ready is always high. Write only while the block is empty.
// Pipeline: a triangle passes 4 cross product, 5 scaling, 8 square root and 7
// division stages, then one output register. The single output channel emits three
// vertices per triangle and so sets the pace; the arithmetic stages accept one
// triangle per cycle while nothing ahead stalls, and buffer up to 24 triangles when
// the output falls behind.
// Reset: all stages empty, colors all ones (0xFFFF).
// Stall: when out_ready is low the current vertex holds, the pipeline fills stage by
// stage, and in_ready drops only once every stage is occupied.
`include "triangle_face_normal_assert.svh"
module triangle_face_normal #(
	parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [COORD_WIDTH-1:0]      a_x,
	input  logic signed [COORD_WIDTH-1:0]      a_y,
	input  logic signed [COORD_WIDTH-1:0]      a_z,
	input  logic signed [COORD_WIDTH-1:0]      b_x,
	input  logic signed [COORD_WIDTH-1:0]      b_y,
	input  logic signed [COORD_WIDTH-1:0]      b_z,
	input  logic signed [COORD_WIDTH-1:0]      c_x,
	input  logic signed [COORD_WIDTH-1:0]      c_y,
	input  logic signed [COORD_WIDTH-1:0]      c_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [COORD_WIDTH-1:0]      pos_x,
	output logic signed [COORD_WIDTH-1:0]      pos_y,
	output logic signed [COORD_WIDTH-1:0]      pos_z,
	output logic signed [tfn_pkg::NORM_W-1:0]  norm_x,
	output logic signed [tfn_pkg::NORM_W-1:0]  norm_y,
	output logic signed [tfn_pkg::NORM_W-1:0]  norm_z,
	output logic [tfn_pkg::COLOR_W-1:0]        out_red,
	output logic [tfn_pkg::COLOR_W-1:0]        out_green,
	output logic [tfn_pkg::COLOR_W-1:0]        out_blue,
	output logic [tfn_pkg::COLOR_W-1:0]        out_alpha,
	output logic                               last_vertex,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tfn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tfn_pkg::COLOR_W-1:0]        cfg_data
);
	localparam int W = COORD_WIDTH;
	localparam int MW = 2 * W + 3;
	localparam int MGW = tfn_pkg::MAG_W;
	localparam int NMW = tfn_pkg::NORM_W;

	typedef enum logic [1:0] {VTX_A, VTX_B, VTX_C} vtx_t;

	// Stage-to-stage handshakes.
	logic cr_valid, cr_ready, sc_valid, sc_ready, sq_valid, sq_ready, div_valid, div_ready;
	logic [9*W-1:0] pos_in, cr_pos, sc_pos, sq_pos, div_pos;
	logic [3*MW-1:0] cr_mag;
	logic [2:0] cr_neg, sc_neg, sq_neg;
	logic [3*MGW-1:0] sc_m, sq_m;
	logic sc_nz, sq_nz;
	logic [tfn_pkg::SUMSQ_W-1:0] sc_sum;
	logic [tfn_pkg::ROOT_W-1:0] sq_root;
	logic [3*NMW-1:0] div_norm;

	// Output register: one triangle, emitted one vertex at a time.
	logic full_q;
	vtx_t cnt_q, cnt_nx;
	logic [9*W-1:0] pos_q;
	logic [3*NMW-1:0] norm_q;
	tfn_pkg::color_t color_q;

	assign pos_in = {c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x};

	tfn_cross #(.W(W)) u_cross (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .pos_in(pos_in),
		.out_valid(cr_valid), .out_ready(cr_ready),
		.pos_out(cr_pos), .mag_out(cr_mag), .neg_out(cr_neg)
	);

	tfn_scale #(.W(W)) u_scale (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cr_valid), .in_ready(cr_ready),
		.pos_in(cr_pos), .mag_in(cr_mag), .neg_in(cr_neg),
		.out_valid(sc_valid), .out_ready(sc_ready),
		.pos_out(sc_pos), .m_out(sc_m), .neg_out(sc_neg), .nz_out(sc_nz), .sum_out(sc_sum)
	);

	tfn_sqrt #(.W(W)) u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sc_valid), .in_ready(sc_ready),
		.pos_in(sc_pos), .m_in(sc_m), .neg_in(sc_neg), .nz_in(sc_nz), .sum_in(sc_sum),
		.out_valid(sq_valid), .out_ready(sq_ready),
		.pos_out(sq_pos), .m_out(sq_m), .neg_out(sq_neg), .nz_out(sq_nz), .root_out(sq_root)
	);

	tfn_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sq_valid), .in_ready(sq_ready),
		.pos_in(sq_pos), .m_in(sq_m), .neg_in(sq_neg), .nz_in(sq_nz), .root_in(sq_root),
		.out_valid(div_valid), .out_ready(div_ready),
		.pos_out(div_pos), .norm_out(div_norm)
	);

	// Take the next triangle when empty or while the last vertex leaves.
	assign div_ready = !full_q || (out_ready && (cnt_q == VTX_C));

	always_comb begin
		case (cnt_q)
			VTX_A:   cnt_nx = VTX_B;
			VTX_B:   cnt_nx = VTX_C;
			default: cnt_nx = VTX_A;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			cnt_q <= VTX_A;
		end else if (div_valid && div_ready) begin
			// load a fresh triangle, start at vertex a
			full_q <= 1'b1;
			cnt_q <= VTX_A;
		end else if (out_valid && out_ready) begin
			// advance, drop the triangle after vertex c
			if (cnt_q == VTX_C) begin
				full_q <= 1'b0;
			end
			cnt_q <= cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (div_valid && div_ready) begin
			pos_q <= div_pos;
			norm_q <= div_norm;
		end
	end

	// Color registers; indexes beyond alpha are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (tfn_pkg::reg_idx_t'(cfg_index))
				tfn_pkg::REG_RED:   color_q.red <= cfg_data;
				tfn_pkg::REG_GREEN: color_q.green <= cfg_data;
				tfn_pkg::REG_BLUE:  color_q.blue <= cfg_data;
				tfn_pkg::REG_ALPHA: color_q.alpha <= cfg_data;
				default:            color_q <= color_q;
			endcase
		end
	end
	assign cfg_ready = 1'b1;

	// Pick the current vertex out of the held triangle.
	always_comb begin
		case (cnt_q)
			VTX_A:   {pos_z, pos_y, pos_x} = pos_q[0 +: 3*W];
			VTX_B:   {pos_z, pos_y, pos_x} = pos_q[3*W +: 3*W];
			VTX_C:   {pos_z, pos_y, pos_x} = pos_q[6*W +: 3*W];
			default: {pos_z, pos_y, pos_x} = pos_q[0 +: 3*W];
		endcase
	end

	assign norm_x = norm_q[0 +: NMW];
	assign norm_y = norm_q[NMW +: NMW];
	assign norm_z = norm_q[2*NMW +: NMW];
	assign out_red = color_q.red;
	assign out_green = color_q.green;
	assign out_blue = color_q.blue;
	assign out_alpha = color_q.alpha;
	assign out_valid = full_q;
	assign last_vertex = full_q && (cnt_q == VTX_C);

	`TFN_ASSERT_NEXT(a_load_starts_at_a, div_valid && div_ready, out_valid && !last_vertex && (cnt_q == VTX_A), "loaded triangle does not start at vertex a")
	`TFN_ASSERT_NEXT(a_mid_vertex_holds, out_valid && out_ready && !last_vertex, out_valid, "triangle dropped before its last vertex")
	`TFN_ASSERT_NEXT(a_drain_empties, out_valid && out_ready && last_vertex && !div_valid, !out_valid, "vertex repeated after the last one")
endmodule

/* bench/tb_top.sv */
// Testbench for triangle_face_normal: directed and random triangles checked against a normal predictor.
`timescale 1ns / 100ps

module tb_top;
	localparam int CW = tfn_pkg::COORD_WIDTH_DEF;
	localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
	localparam logic signed [CW-1:0] CMAX = 32'sh7FFF_FFFF;
	localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [tfn_pkg::NORM_W-1:0] nval_t;

	// One triangle: vertex a, b, c as x, y, z each.
	typedef struct {
		coord_t p[9];
	} tri_t;

	typedef struct {
		nval_t x, y, z;
	} normal_t;

	// One vertex as the block should emit it.
	typedef struct {
		coord_t px, py, pz;
		normal_t n;
		tfn_pkg::color_t col;
		logic last;
	} vertex_t;

	// Directed row: the normal is typed in where it is obvious, else predicted.
	typedef struct {
		tri_t t;
		bit known;
		normal_t n;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	coord_t a_x = '0, a_y = '0, a_z = '0;
	coord_t b_x = '0, b_y = '0, b_z = '0;
	coord_t c_x = '0, c_y = '0, c_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	coord_t pos_x, pos_y, pos_z;
	nval_t norm_x, norm_y, norm_z;
	logic [tfn_pkg::COLOR_W-1:0] out_red, out_green, out_blue, out_alpha;
	logic last_vertex;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tfn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tfn_pkg::COLOR_W-1:0] cfg_data = '0;

	triangle_face_normal dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Current color registers as the block should hold them.
	tfn_pkg::color_t colors = '{red: 16'hFFFF, green: 16'hFFFF, blue: 16'hFFFF,
		alpha: 16'hFFFF};
	vertex_t pending_vertices[$];
	int errors = 0;
	int tris_taken = 0;
	bit calm = 1'b0;       // no random gaps on either side while set
	bit stim_done = 1'b0;

	// Exact face normal: full-width cross product, threshold, shared scaling, root, divide.
	function automatic normal_t face_normal(tri_t t);
		logic signed [67:0] e[6];
		logic signed [67:0] cr[3];
		logic [139:0] m[3];
		logic [139:0] sumsq, r, q, trial;
		bit neg[3];
		nval_t res[3];
		normal_t n;
		for (int i = 0; i < 3; i++) begin
			e[i] = 68'(t.p[3 + i]) - 68'(t.p[i]);
			e[3 + i] = 68'(t.p[6 + i]) - 68'(t.p[i]);
		end
		cr[0] = e[1] * e[5] - e[2] * e[4];
		cr[1] = e[2] * e[3] - e[0] * e[5];
		cr[2] = e[0] * e[4] - e[1] * e[3];
		for (int i = 0; i < 3; i++) begin
			neg[i] = cr[i] < 0;
			m[i] = 140'(neg[i] ? -cr[i] : cr[i]);
		end
		sumsq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		if (sumsq <= 140'(tfn_pkg::LEN_LIMIT_SQ)) begin
			n.x = '0;
			n.y = 16'sd32767;
			n.z = '0;
			return n;
		end
		// Shift all three together until every magnitude is below 2^31.
		while ((m[0] | m[1] | m[2]) >= 140'h8000_0000) begin
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
		end
		sumsq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			trial = r | (140'd1 << b);
			if (trial * trial <= sumsq) r = trial;
		end
		for (int i = 0; i < 3; i++) begin
			q = (r == 0) ? '0 : (m[i] * 32768 + (r >> 1)) / r;
			if (!neg[i]) res[i] = (q > 32767) ? 16'sd32767 : nval_t'(q);
			else res[i] = (q > 32768) ? nval_t'(-32768) : nval_t'(-$signed(17'(q)));
		end
		n.x = res[0];
		n.y = res[1];
		n.z = res[2];
		return n;
	endfunction

	// Queue the three vertices that one taken triangle must produce.
	task automatic push_vertices(tri_t t, normal_t n);
		vertex_t v;
		for (int k = 0; k < 3; k++) begin
			v.px = t.p[3 * k];
			v.py = t.p[3 * k + 1];
			v.pz = t.p[3 * k + 2];
			v.n = n;
			v.col = colors;
			v.last = (k == 2);
			pending_vertices.push_back(v);
		end
	endtask

	// Pick an idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one triangle, hold it until taken, then predict it.
	task automatic send_tri(tri_t t, bit known, normal_t typed);
		int gap;
		{a_x, a_y, a_z} <= {t.p[0], t.p[1], t.p[2]};
		{b_x, b_y, b_z} <= {t.p[3], t.p[4], t.p[5]};
		{c_x, c_y, c_z} <= {t.p[6], t.p[7], t.p[8]};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		push_vertices(t, known ? typed : face_normal(t));
		tris_taken++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_color(tfn_pkg::reg_idx_t idx, logic [tfn_pkg::COLOR_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			tfn_pkg::REG_RED: colors.red = val;
			tfn_pkg::REG_GREEN: colors.green = val;
			tfn_pkg::REG_BLUE: colors.blue = val;
			tfn_pkg::REG_ALPHA: colors.alpha = val;
			default: ;
		endcase
	endtask

	// Drop valid and wait until the pipeline has drained completely.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic coord_t pick_extreme();
		case ($urandom_range(0, 4))
			0: return CMIN;
			1: return CMAX;
			2: return '0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// Random triangle; the mix leans on valid geometry with some near the threshold.
	function automatic tri_t random_tri();
		tri_t t;
		int mode, sh, d1, d2, k;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) t.p[i] = $urandom;
		case (mode)
			4, 5: begin
				sh = $urandom_range(0, 20);
				for (int i = 3; i < 9; i++)
					t.p[i] = t.p[i % 3] + coord_t'($signed($urandom) >>> (31 - sh));
			end
			6: begin
				// Right triangle with area right around the length threshold.
				d1 = $urandom_range(1, 8);
				d2 = 429497 / d1 + $urandom_range(0, 4) - 2;
				t.p[3] = t.p[0] + d1;
				t.p[4] = t.p[1];
				t.p[5] = t.p[2];
				t.p[6] = t.p[0];
				t.p[7] = t.p[1] + ($urandom_range(0, 1) ? d2 : -d2);
				t.p[8] = t.p[2];
			end
			7: begin
				// Collinear: c lies on the line through a and b.
				k = $urandom_range(0, 3);
				for (int i = 0; i < 3; i++) begin
					t.p[3 + i] = t.p[i] + coord_t'($signed($urandom) >>> 16);
					t.p[6 + i] = t.p[i] + k * (t.p[3 + i] - t.p[i]);
				end
			end
			8: for (int i = 0; i < 9; i++) t.p[i] = pick_extreme();
			9: for (int i = 3; i < 9; i++) t.p[i] = t.p[i % 3] + $urandom_range(0, 3);
			default: ;
		endcase
		return t;
	endfunction

	function automatic row_t mk_row(coord_t p[9], bit known, nval_t nx, nval_t ny, nval_t nz);
		row_t r;
		r.t.p = p;
		r.known = known;
		r.n = '{x: nx, y: ny, z: nz};
		return r;
	endfunction

	row_t directed[$];

	initial begin
		tri_t t;
		normal_t none;
		none = '{default: '0};
		directed = '{
			mk_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 32767, 0),
			mk_row('{0, 0, 0, ONE, 0, 0, 0, ONE, 0}, 1, 0, 0, 32767),
			mk_row('{0, 0, 0, ONE, 0, 0, 0, -ONE, 0}, 1, 0, 0, -32768),
			mk_row('{0, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1, 32767, 0, 0),
			mk_row('{0, 0, 0, 0, 0, ONE, ONE, 0, 0}, 1, 0, 32767, 0),
			// just above and just below the length threshold
			mk_row('{0, 0, 0, 1, 0, 0, 0, 429497, 0}, 1, 0, 0, 32767),
			mk_row('{0, 0, 0, 1, 0, 0, 0, 429496, 0}, 1, 0, 32767, 0),
			mk_row('{0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE}, 1, 0, 32767, 0),
			mk_row('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1, 0, 32767, 0),
			mk_row('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1, 0, 32767, 0),
			mk_row('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX}, 0, 0, 0, 0),
			mk_row('{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN}, 0, 0, 0, 0),
			mk_row('{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN}, 0, 0, 0, 0),
			mk_row('{0, 0, 0, ONE, 0, 0, ONE, ONE, 0}, 0, 0, 0, 0),
			mk_row('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 0, 0, 0, 0),
			mk_row('{-1, -1, -1, 1, 1, -1, -1, 1, 1}, 0, 0, 0, 0)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs on the reset colors.
		foreach (directed[i]) send_tri(directed[i].t, directed[i].known, directed[i].n);
		drain();

		// Random phases, each with its own color setting, extremes first.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_color(tfn_pkg::REG_RED, 16'h0000);
					write_color(tfn_pkg::REG_GREEN, 16'h0000);
					write_color(tfn_pkg::REG_BLUE, 16'h0000);
					write_color(tfn_pkg::REG_ALPHA, 16'h0000);
				end
				1: begin
					write_color(tfn_pkg::REG_RED, 16'hFFFF);
					write_color(tfn_pkg::REG_GREEN, 16'hFFFF);
					write_color(tfn_pkg::REG_BLUE, 16'hFFFF);
					write_color(tfn_pkg::REG_ALPHA, 16'hFFFF);
				end
				2: begin
					write_color(tfn_pkg::REG_RED, 16'hA5A5);
					write_color(tfn_pkg::REG_GREEN, 16'h5A5A);
					write_color(tfn_pkg::REG_BLUE, 16'h0001);
					write_color(tfn_pkg::REG_ALPHA, 16'h8000);
				end
				default: begin
					write_color(tfn_pkg::REG_RED, 16'($urandom));
					write_color(tfn_pkg::REG_GREEN, 16'($urandom));
					write_color(tfn_pkg::REG_BLUE, 16'($urandom));
					write_color(tfn_pkg::REG_ALPHA, 16'($urandom));
				end
			endcase
			@(posedge clk);
			calm = (ph == 1);
			for (int n = 0; n < 80; n++) begin
				t = random_tri();
				send_tri(t, 1'b0, none);
			end
			calm = 1'b0;
			drain();
		end
		stim_done = 1'b1;
	end

	// Output side: random stalls, and one long hold-off so the pipeline fills up.
	initial begin
		int stall;
		bit long_done;
		stall = 0;
		long_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!long_done && tris_taken >= 120) begin
				long_done = 1'b1;
				stall = 300;
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) stall = pick_gap();
			end
		end
	end

	task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	// Compare every taken vertex with the oldest one waiting.
	always @(posedge clk) begin
		vertex_t v;
		if (arst_n && out_valid && out_ready) begin
			if (pending_vertices.size() == 0) begin
				$error("vertex with nothing pending: pos %h %h %h", pos_x, pos_y, pos_z);
				errors++;
			end else begin
				v = pending_vertices.pop_front();
				check_field("pos_x", v.px, pos_x);
				check_field("pos_y", v.py, pos_y);
				check_field("pos_z", v.pz, pos_z);
				check_field("norm_x", CW'(v.n.x), CW'(norm_x));
				check_field("norm_y", CW'(v.n.y), CW'(norm_y));
				check_field("norm_z", CW'(v.n.z), CW'(norm_z));
				check_field("out_red", CW'(v.col.red), CW'(out_red));
				check_field("out_green", CW'(v.col.green), CW'(out_green));
				check_field("out_blue", CW'(v.col.blue), CW'(out_blue));
				check_field("out_alpha", CW'(v.col.alpha), CW'(out_alpha));
				check_field("last_vertex", CW'(v.last), CW'(last_vertex));
			end
		end
	end

	// Finish once stimulus is done and the drain pause has passed.
	initial begin
		wait (stim_done);
		if (errors == 0 && pending_vertices.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

/* files.f */
+incdir+sv
sv/tfn_pkg.sv
sv/tfn_cross.sv
sv/tfn_scale.sv
sv/tfn_sqrt.sv
sv/tfn_div.sv
sv/triangle_face_normal.sv
bench/tb_top.sv
